// ===== hw/rtl/glyph_line_page_placer_top_assert.svh =====
// Assertion macros for the glyph line and page placer
`ifndef GLYPH_LINE_PAGE_PLACER_TOP_ASSERT_SVH
`define GLYPH_LINE_PAGE_PLACER_TOP_ASSERT_SVH

`ifndef SYNTH
`define GLPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GLPP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GLPP_ASSERT(lbl, prop, msg)
`define GLPP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/glpp_pkg.sv =====
// Package: op codes, register indexes and reset values for the glyph placer
`timescale 1ns / 1ps

package glpp_pkg;

  typedef enum logic [1:0] {
    OP_PLACE = 2'd0,
    OP_LINE  = 2'd1,
    OP_PAGE  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_PAGE_WIDTH   = 3'd0,
    CFG_PAGE_HEIGHT  = 3'd1,
    CFG_HORIZ_MARGIN = 3'd2,
    CFG_VERT_MARGIN  = 3'd3,
    CFG_LINE_SPACING = 3'd4,
    CFG_WORD_SPACING = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 12;
  localparam int unsigned PageBits    = 12;
  localparam int unsigned MarginBits  = 10;
  localparam int unsigned SpacingBits = 8;
  localparam int unsigned BaseBits    = 10;
  localparam int unsigned HeightBits  = 11;

  localparam logic [PageBits-1:0]    PageWidthRst  = 12'd800;
  localparam logic [PageBits-1:0]    PageHeightRst = 12'd600;
  localparam logic [MarginBits-1:0]  HMarginRst    = 10'd10;
  localparam logic [MarginBits-1:0]  VMarginRst    = 10'd10;
  localparam logic [SpacingBits-1:0] LineSpaceRst  = 8'd4;
  localparam logic [SpacingBits-1:0] WordSpaceRst  = 8'd2;

endpackage

// ===== hw/rtl/glyph_line_page_placer_top.sv =====
// Glyph line and page placer: input register, placement logic, result register
//
//   channel | direction | handshake            | words
//   cfg     | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//   in      | in        | in_valid_i/in_stall_o | op_i, glyph_width_i/height_i/bearing_i
//   out     | out       | out_valid_o/out_stall_i | placed_o, pos_x_o, pos_y_o
//
// One input word per cycle while in_stall_o is low; a place word is held in the input
// register and its result is then registered in the result register.
// The cursor and line state feed back through the combinational placement logic.
// Reset puts the cursor at the margins and loads default register values.
// A held result stalls only place words; line, page and unused words pass on.
`timescale 1ns / 1ps
`include "glyph_line_page_placer_top_assert.svh"

module glyph_line_page_placer_top
  import glpp_pkg::*;
#(
  parameter int unsigned COORD_BITS = 14,
  parameter int unsigned GLYPH_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [CfgDataBits-1:0]       cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [GLYPH_BITS-1:0]        glyph_width_i,
  input  logic [GLYPH_BITS-1:0]        glyph_height_i,
  input  logic signed [GLYPH_BITS-1:0] glyph_bearing_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         placed_o,
  output logic signed [COORD_BITS-1:0] pos_x_o,
  output logic signed [COORD_BITS-1:0] pos_y_o
);

  localparam int unsigned W = ((COORD_BITS > PageBits) ? COORD_BITS : PageBits) + 3;
  localparam logic signed [W-1:0] CMax = W'((2 ** (COORD_BITS - 1)) - 1);
  localparam logic signed [W-1:0] CMin = -CMax - W'(1);
  localparam logic signed [W-1:0] BMax = W'((2 ** (BaseBits - 1)) - 1);
  localparam logic signed [W-1:0] BMin = -BMax - W'(1);
  localparam logic signed [W-1:0] HMax = W'((2 ** HeightBits) - 1);

  function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = v;
    if (v > CMax) r = CMax;
    if (v < CMin) r = CMin;
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [BaseBits-1:0] sat_b(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = v;
    if (v > BMax) r = BMax;
    if (v < BMin) r = BMin;
    return r[BaseBits-1:0];
  endfunction

  function automatic logic [HeightBits-1:0] sat_h(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = v;
    if (v > HMax) r = HMax;
    if (v < W'(0)) r = '0;
    return r[HeightBits-1:0];
  endfunction

  // configuration registers
  logic [PageBits-1:0]    page_w_q, page_h_q;
  logic [MarginBits-1:0]  h_margin_q, v_margin_q;
  logic [SpacingBits-1:0] line_sp_q, word_sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_w_q   <= PageWidthRst;
      page_h_q   <= PageHeightRst;
      h_margin_q <= HMarginRst;
      v_margin_q <= VMarginRst;
      line_sp_q  <= LineSpaceRst;
      word_sp_q  <= WordSpaceRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PAGE_WIDTH:   page_w_q   <= cfg_data_i[PageBits-1:0];
        CFG_PAGE_HEIGHT:  page_h_q   <= cfg_data_i[PageBits-1:0];
        CFG_HORIZ_MARGIN: h_margin_q <= cfg_data_i[MarginBits-1:0];
        CFG_VERT_MARGIN:  v_margin_q <= cfg_data_i[MarginBits-1:0];
        CFG_LINE_SPACING: line_sp_q  <= cfg_data_i[SpacingBits-1:0];
        CFG_WORD_SPACING: word_sp_q  <= cfg_data_i[SpacingBits-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                         in_valid_q;
  logic [1:0]                   in_op_q;
  logic [GLYPH_BITS-1:0]        in_gw_q, in_gh_q;
  logic signed [GLYPH_BITS-1:0] in_gb_q;
  logic                         is_place, proc, in_load;

  assign is_place   = (op_e'(in_op_q) == OP_PLACE);
  assign proc       = in_valid_q && (!is_place || !out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load || proc) begin
      in_valid_q <= in_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_op_q <= op_i;
      in_gw_q <= glyph_width_i;
      in_gh_q <= glyph_height_i;
      in_gb_q <= glyph_bearing_i;
    end
  end

  // line and cursor state
  logic signed [COORD_BITS-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic signed [BaseBits-1:0]   line_base_q, line_base_d;
  logic [HeightBits-1:0]        line_h_q, line_h_d;

  logic signed [W-1:0] cx, cy, bl, lh, gw, gh, gb, ws, ls, hm, vm, pw, ph;
  logic signed [W-1:0] bl_max, d, t, lh_max, bl1_w, lh1_w, cx2, cy2, bl2_w, hm_sat_w;
  logic signed [BaseBits-1:0]   bl1, bl2;
  logic [HeightBits-1:0]        lh1, lh2;
  logic                         fit, full, drop;
  logic signed [COORD_BITS-1:0] px, py, hm_sat, vm_sat;

  always_comb begin
    cx = W'(cursor_x_q);
    cy = W'(cursor_y_q);
    bl = W'(line_base_q);
    lh = W'(line_h_q);
    gw = W'(in_gw_q);
    gh = W'(in_gh_q);
    gb = W'(in_gb_q);
    ws = W'(word_sp_q);
    ls = W'(line_sp_q);
    hm = W'(h_margin_q);
    vm = W'(v_margin_q);
    pw = W'(page_w_q);
    ph = W'(page_h_q);

    hm_sat   = sat_c(hm);
    vm_sat   = sat_c(vm);
    hm_sat_w = W'(hm_sat);

    bl_max = (gb > bl) ? gb : bl;
    bl1    = sat_b(bl_max);
    bl1_w  = W'(bl1);
    d      = gh - gb;
    t      = bl1_w + d;
    lh_max = (t > lh) ? t : lh;
    lh1    = sat_h(lh_max);
    lh1_w  = W'(lh1);

    fit  = (cx + ws + gw) < (pw - hm);
    full = (cy + ls + lh1_w) >= (ph - vm);
    drop = !fit && full;

    cx2 = fit ? cx : hm_sat_w;
    cy2 = fit ? cy : W'(sat_c(cy + ls + lh1_w));
    bl2 = fit ? bl1 : sat_b(gb);
    lh2 = fit ? lh1 : sat_h(gh);
    bl2_w = W'(bl2);

    px = cx2[COORD_BITS-1:0];
    py = sat_c(cy2 + bl2_w + d);
  end

  always_comb begin
    cursor_x_d  = cursor_x_q;
    cursor_y_d  = cursor_y_q;
    line_base_d = line_base_q;
    line_h_d    = line_h_q;
    case (op_e'(in_op_q))
      OP_PLACE: begin
        if (drop) begin
          cursor_x_d  = hm_sat;
          cursor_y_d  = vm_sat;
          line_base_d = '0;
          line_h_d    = '0;
        end else begin
          cursor_x_d  = sat_c(cx2 + gw + ws);
          cursor_y_d  = cy2[COORD_BITS-1:0];
          line_base_d = bl2;
          line_h_d    = lh2;
        end
      end
      OP_LINE: begin
        cursor_x_d  = hm_sat;
        cursor_y_d  = sat_c(cy + lh + ls);
        line_base_d = '0;
        line_h_d    = '0;
      end
      OP_PAGE: begin
        cursor_x_d  = hm_sat;
        cursor_y_d  = vm_sat;
        line_base_d = '0;
        line_h_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q  <= COORD_BITS'(HMarginRst);
      cursor_y_q  <= COORD_BITS'(VMarginRst);
      line_base_q <= '0;
      line_h_q    <= '0;
    end else if (proc) begin
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      line_base_q <= line_base_d;
      line_h_q    <= line_h_d;
    end
  end

  // result register
  logic                         out_valid_q, placed_q;
  logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic                         res_load;

  assign res_load = proc && is_place;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      placed_q <= !drop;
      pos_x_q  <= drop ? '0 : px;
      pos_y_q  <= drop ? '0 : py;
    end
  end

  assign out_valid_o = out_valid_q;
  assign placed_o    = placed_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;

  `GLPP_ASSERT(a_drop_zero, (out_valid_o && !placed_o) |-> (pos_x_o | pos_y_o) == '0, "drop pos")
  `GLPP_ASSERT_IMPL(a_drop_clr, res_load && drop, line_h_q == '0 && line_base_q == '0, "line kept")
  `GLPP_ASSERT_IMPL(a_in_hold, in_valid_q && in_stall_o, in_valid_q, "stalled input word lost")
  `GLPP_ASSERT(a_res_room, res_load |-> (!out_valid_q || !out_stall_i), "result overwritten")

endmodule

// ===== test/tb_glyph_line_page_placer_top.sv =====
// Testbench for the glyph line and page placer: directed and random words checked by a scoreboard
`timescale 1ns / 1ps

module tb_glyph_line_page_placer_top;
  import glpp_pkg::*;

  localparam int unsigned CoordBits   = 14;
  localparam int unsigned GlyphBits   = 8;
  localparam int unsigned Limit       = 200000;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned IdlePct     = 32;
  localparam logic [1:0] OpSpare = 2'd3;
  localparam logic [CfgIdxBits-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    logic                        placed;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } glyph_pos_t;

  class placement_board;
    int page_w, page_h, margin_h, margin_v, gap_line, gap_word;
    int cur_x, cur_y, base, height;
    glyph_pos_t pos_q[$];
    int unsigned errors;

    function new();
      page_w   = int'(PageWidthRst);
      page_h   = int'(PageHeightRst);
      margin_h = int'(HMarginRst);
      margin_v = int'(VMarginRst);
      gap_line = int'(LineSpaceRst);
      gap_word = int'(WordSpaceRst);
      errors   = 0;
      go_page_top();
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int sat(int v);
      return clamp(v, -(1 << (CoordBits - 1)), (1 << (CoordBits - 1)) - 1);
    endfunction

    function void go_page_top();
      cur_x  = sat(margin_h);
      cur_y  = sat(margin_v);
      base   = 0;
      height = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MaxReported) $display("%s", msg);
    endfunction

    function void load_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
      case (idx)
        CFG_PAGE_WIDTH:   page_w   = int'(data[PageBits-1:0]);
        CFG_PAGE_HEIGHT:  page_h   = int'(data[PageBits-1:0]);
        CFG_HORIZ_MARGIN: margin_h = int'(data[MarginBits-1:0]);
        CFG_VERT_MARGIN:  margin_v = int'(data[MarginBits-1:0]);
        CFG_LINE_SPACING: gap_line = int'(data[SpacingBits-1:0]);
        CFG_WORD_SPACING: gap_word = int'(data[SpacingBits-1:0]);
        default: ;
      endcase
    endfunction

    function void note_word(logic [1:0] op, logic [GlyphBits-1:0] w,
                            logic [GlyphBits-1:0] h, logic signed [GlyphBits-1:0] b);
      int gw, gh, gb, d, px, py;
      glyph_pos_t p;
      gw = int'(w);
      gh = int'(h);
      gb = int'(b);
      case (op)
        OP_LINE: begin
          cur_x  = sat(margin_h);
          cur_y  = sat(cur_y + height + gap_line);
          base   = 0;
          height = 0;
        end
        OP_PAGE: go_page_top();
        OP_PLACE: begin
          if (gb > base) base = gb;
          base = clamp(base, -512, 511);
          d = gh - gb;
          if (base + d > height) height = base + d;
          height = clamp(height, 0, 2047);
          if (cur_x + gap_word + gw >= page_w - margin_h) begin
            if (cur_y + gap_line + height >= page_h - margin_v) begin
              go_page_top();
              p = '0;
              pos_q.push_back(p);
              return;
            end
            cur_x  = sat(margin_h);
            cur_y  = sat(cur_y + gap_line + height);
            base   = clamp(gb, -512, 511);
            height = clamp(gh, 0, 2047);
          end
          px = cur_x;
          py = sat(cur_y + base + d);
          cur_x = sat(cur_x + gw + gap_word);
          p.placed = 1'b1;
          p.x = px[CoordBits-1:0];
          p.y = py[CoordBits-1:0];
          pos_q.push_back(p);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic placed, logic signed [CoordBits-1:0] x,
                               logic signed [CoordBits-1:0] y);
      glyph_pos_t p;
      if (pos_q.size() == 0) begin
        flag($sformatf("unexpected result: placed=%0d x=%0d y=%0d", placed, x, y));
        return;
      end
      p = pos_q.pop_front();
      if (p.placed !== placed || p.x !== x || p.y !== y)
        flag($sformatf("mismatch: expected placed=%0d x=%0d y=%0d, got placed=%0d x=%0d y=%0d",
                       p.placed, p.x, p.y, placed, x, y));
    endfunction

    function void close();
      if (pos_q.size() != 0) flag($sformatf("%0d results never arrived", pos_q.size()));
    endfunction
  endclass

  logic                        clk_i           = 1'b0;
  logic                        rst_ni          = 1'b0;
  logic                        cfg_we_i        = 1'b0;
  logic [CfgIdxBits-1:0]       cfg_idx_i       = '0;
  logic [CfgDataBits-1:0]      cfg_data_i      = '0;
  logic                        in_valid_i      = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  op_i            = OP_PLACE;
  logic [GlyphBits-1:0]        glyph_width_i   = '0;
  logic [GlyphBits-1:0]        glyph_height_i  = '0;
  logic signed [GlyphBits-1:0] glyph_bearing_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i     = 1'b0;
  logic                        placed_o;
  logic signed [CoordBits-1:0] pos_x_o;
  logic signed [CoordBits-1:0] pos_y_o;

  bit          steady = 1'b0;
  int unsigned cycles = 0;
  placement_board board;

  glyph_line_page_placer_top #(
    .COORD_BITS(CoordBits),
    .GLYPH_BITS(GlyphBits)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .glyph_width_i,
    .glyph_height_i,
    .glyph_bearing_i,
    .out_valid_o,
    .out_stall_i,
    .placed_o,
    .pos_x_o,
    .pos_y_o
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (cycles >= Limit) begin
      $display("FAILURE");
      $finish;
    end else begin
      cycles <= cycles + 1;
      if (rst_ni && out_valid_o && !out_stall_i)
        board.check_result(placed_o, pos_x_o, pos_y_o);
      out_stall_i <= !steady && ($urandom_range(99) < IdlePct);
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [GlyphBits-1:0] w,
                           input logic [GlyphBits-1:0] h,
                           input logic signed [GlyphBits-1:0] b);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    glyph_width_i   <= w;
    glyph_height_i  <= h;
    glyph_bearing_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_word(op, w, h, b);
  endtask

  task automatic random_words(input int unsigned n, input int unsigned line_pct,
                              input int unsigned page_pct);
    int unsigned sent;
    int unsigned roll;
    logic [1:0]  op;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(99);
      if (roll < 4) op = OpSpare;
      else if (roll < 4 + line_pct) op = OP_LINE;
      else if (roll < 4 + line_pct + page_pct) op = OP_PAGE;
      else op = OP_PLACE;
      send_word(op, GlyphBits'($urandom), GlyphBits'($urandom), GlyphBits'($urandom));
      if (op != OpSpare) sent++;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pos_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.load_reg(idx, data);
  endtask

  task automatic set_regs(input logic [CfgDataBits-1:0] pw, input logic [CfgDataBits-1:0] ph,
                          input logic [CfgDataBits-1:0] hm, input logic [CfgDataBits-1:0] vm,
                          input logic [CfgDataBits-1:0] ls, input logic [CfgDataBits-1:0] ws);
    write_reg(CFG_PAGE_WIDTH, pw);
    write_reg(CFG_PAGE_HEIGHT, ph);
    write_reg(CFG_HORIZ_MARGIN, hm);
    write_reg(CFG_VERT_MARGIN, vm);
    write_reg(CFG_LINE_SPACING, ls);
    write_reg(CFG_WORD_SPACING, ws);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_PLACE, 0, 0, 0);
    send_word(OP_PLACE, 255, 255, 127);
    send_word(OP_PLACE, 255, 255, -128);
    send_word(OP_PLACE, 1, 0, -128);
    send_word(OpSpare, 255, 255, -1);
    send_word(OP_LINE, 0, 0, 0);
    send_word(OP_PLACE, 128, 1, 1);
    send_word(OP_PAGE, 255, 255, 127);
    for (int i = 0; i < 8; i++) send_word(OP_PLACE, 255, 255, -128);
    send_word(OP_LINE, 255, 255, -128);
    send_word(OP_PAGE, 0, 0, 0);
    send_word(OP_PLACE, 0, 255, 127);
    random_words(50, 8, 4);
    drain();

    set_regs(0, 0, 0, 0, 0, 0);
    send_word(OP_PLACE, 0, 0, 0);
    send_word(OP_PLACE, 255, 255, -128);
    send_word(OP_LINE, 0, 0, 0);
    random_words(25, 8, 4);
    drain();

    set_regs(4095, 4095, 1023, 1023, 255, 255);
    random_words(50, 8, 4);
    drain();

    set_regs(300, 200, 20, 20, 3, 1);
    random_words(60, 5, 2);
    drain();

    // drive the line cursor into saturation
    set_regs(4095, 4095, 0, 0, 255, 0);
    random_words(80, 45, 0);
    drain();

    steady = 1'b1;
    set_regs(640, 480, 8, 8, 2, 1);
    random_words(60, 8, 4);
    drain();
    steady = 1'b0;

    write_reg(CfgSpareLo, CfgDataBits'($urandom));
    write_reg(CfgSpareHi, CfgDataBits'($urandom));
    set_regs(CfgDataBits'($urandom), CfgDataBits'($urandom), CfgDataBits'($urandom),
             CfgDataBits'($urandom), CfgDataBits'($urandom), CfgDataBits'($urandom));
    random_words(50, 8, 4);
    drain();

    set_regs(CfgDataBits'($urandom_range(4095)), CfgDataBits'($urandom_range(4095)),
             CfgDataBits'($urandom_range(200)), CfgDataBits'($urandom_range(200)),
             CfgDataBits'($urandom_range(255)), CfgDataBits'($urandom_range(255)));
    random_words(50, 8, 4);
    drain();

    repeat (8) @(posedge clk_i);
    board.close();
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/glpp_pkg.sv
hw/rtl/glyph_line_page_placer_top.sv
test/tb_glyph_line_page_placer_top.sv
